FILE: design/plane_normalizer_assert.svh
// Assertion macros used by the plane normalizer checker.
`ifndef PLANE_NORMALIZER_ASSERT_SVH
`define PLANE_NORMALIZER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PN_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PN_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/pn_pkg.sv
`default_nettype none

package pn_pkg;

   // Coefficient format: signed fixed point, Q16.16.
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int SUM_BITS  = 2 * WORD_BITS;
   localparam int DIV_BITS  = WORD_BITS + FRAC_BITS;
   localparam int SQ_STAGES = WORD_BITS;
   localparam int DV_STAGES = DIV_BITS;

   typedef logic        [WORD_BITS-1:0] word_type;
   typedef logic signed [WORD_BITS-1:0] sword_type;

   typedef struct packed {
      sword_type coef_a;
      sword_type coef_b;
      sword_type coef_c;
      sword_type coef_d;
   } req_type;

   typedef struct packed {
      sword_type norm_a;
      sword_type norm_b;
      sword_type norm_c;
      sword_type norm_d;
      logic      degenerate;
   } rsp_type;

   // Magnitudes and signs of the four coefficients.
   typedef struct packed {
      logic [3:0][WORD_BITS-1:0] mag;
      logic [3:0]                neg;
   } coef_type;

   // One digit step of the square root.
   typedef struct packed {
      logic [SUM_BITS-1:0]  x;
      logic [WORD_BITS:0]   rem;
      word_type             root;
      coef_type             coef;
   } sq_stage_type;

   // One quotient-bit step of the four dividers.
   typedef struct packed {
      word_type                  len;
      logic                      deg;
      logic [3:0][DIV_BITS-1:0]  num;
      logic [3:0][WORD_BITS:0]   rem;
      logic [3:0]                neg;
   } dv_stage_type;

   function automatic word_type magnitude(sword_type v);
      return v[WORD_BITS-1] ? word_type'(-v) : word_type'(v);
   endfunction

   // Consume the top two radicand bits and decide one root bit.
   function automatic sq_stage_type sqrt_step(sq_stage_type s);
      sq_stage_type             r;
      logic [WORD_BITS+2:0]     pre;
      logic [WORD_BITS+2:0]     trial;
      logic [WORD_BITS+2:0]     diff;
      r     = s;
      pre   = {s.rem, s.x[SUM_BITS-1:SUM_BITS-2]};
      trial = {1'b0, s.root, 2'b01};
      diff  = pre - trial;
      r.x   = {s.x[SUM_BITS-3:0], 2'b00};
      if (pre >= trial) begin
         r.rem  = diff[WORD_BITS:0];
         r.root = {s.root[WORD_BITS-2:0], 1'b1};
      end else begin
         r.rem  = pre[WORD_BITS:0];
         r.root = {s.root[WORD_BITS-2:0], 1'b0};
      end
      return r;
   endfunction

   // One restoring division step on each coefficient; the quotient
   // shifts into the low end of num as the dividend leaves the top.
   function automatic dv_stage_type div_step(dv_stage_type s);
      dv_stage_type         r;
      logic [WORD_BITS:0]   pre;
      r = s;
      for (int i = 0; i < 4; i++) begin
         pre = {s.rem[i][WORD_BITS-1:0], s.num[i][DIV_BITS-1]};
         if (pre >= {1'b0, s.len}) begin
            r.rem[i] = pre - {1'b0, s.len};
            r.num[i] = {s.num[i][DIV_BITS-2:0], 1'b1};
         end else begin
            r.rem[i] = pre;
            r.num[i] = {s.num[i][DIV_BITS-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   // Clamp a quotient magnitude to the signed word and apply the sign.
   function automatic sword_type saturate(logic [DIV_BITS-1:0] q, logic neg);
      logic [DIV_BITS-1:0] lim;
      logic [DIV_BITS-1:0] v;
      lim = DIV_BITS'(1) << (WORD_BITS - 1);
      if (neg) begin
         v = (q > lim) ? lim : q;
         return sword_type'(-v[WORD_BITS-1:0]);
      end
      v = (q > lim - DIV_BITS'(1)) ? lim - DIV_BITS'(1) : q;
      return sword_type'(v[WORD_BITS-1:0]);
   endfunction

endpackage

`default_nettype wire

FILE: design/plane_normalizer.sv
// Plane normalizer: takes one plane a*x + b*y + c*z + d = 0 per item in
// signed Q16.16 and returns each coefficient divided by the normal length
// L = floor(sqrt(a*a + b*b + c*c)), truncated toward zero and saturated to
// 32 bits. A zero normal returns all zeros with degenerate set. The block
// takes one item every clock unless stalled; each item passes 85 register
// stages: input, square and sum stages, 32 square-root digit stages, the
// divider setup stage, 48 divider quotient-bit stages, then the output
// register. The whole pipeline advances together and holds while a result
// waits on rsp_ready.
`default_nettype none

module plane_normalizer import pn_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic en;

   coef_type                   in_ff;
   logic                       in_vld_ff;
   logic [2:0][SUM_BITS-1:0]   sqr_ff;
   coef_type                   sqr_coef_ff;
   logic                       sqr_vld_ff;
   sq_stage_type               sq_ff  [SQ_STAGES+1];
   logic [SQ_STAGES:0]         sq_vld_ff;
   dv_stage_type               dv_ff  [DV_STAGES+1];
   logic [DV_STAGES:0]         dv_vld_ff;
   rsp_type                    out_ff;
   logic                       out_vld_ff;
   rsp_type                    out_in;

   // The pipeline moves whenever the result register is free or being taken.
   assign en        = !out_vld_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // Input stage: magnitudes and signs.
   always_ff @(posedge clock) begin
      if (en) begin
         in_ff.mag[0] <= magnitude(req_data.coef_a);
         in_ff.mag[1] <= magnitude(req_data.coef_b);
         in_ff.mag[2] <= magnitude(req_data.coef_c);
         in_ff.mag[3] <= magnitude(req_data.coef_d);
         in_ff.neg    <= {req_data.coef_d[WORD_BITS-1], req_data.coef_c[WORD_BITS-1],
                          req_data.coef_b[WORD_BITS-1], req_data.coef_a[WORD_BITS-1]};
      end
   end

   // Square stage: one multiplier per normal component.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sqr_ff[i] <= SUM_BITS'(in_ff.mag[i]) * SUM_BITS'(in_ff.mag[i]);
         end
         sqr_coef_ff <= in_ff;
      end
   end

   // Sum stage loads the first square-root step.
   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0].x    <= sqr_ff[0] + sqr_ff[1] + sqr_ff[2];
         sq_ff[0].rem  <= '0;
         sq_ff[0].root <= '0;
         sq_ff[0].coef <= sqr_coef_ff;
      end
   end

   // Square-root digit stages, one root bit each.
   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[k+1] <= sqrt_step(sq_ff[k]);
         end
      end
   end

   // Divider setup: dividends are the magnitudes shifted up by the fraction.
   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0].len <= sq_ff[SQ_STAGES].root;
         dv_ff[0].deg <= (sq_ff[SQ_STAGES].root == '0);
         dv_ff[0].neg <= sq_ff[SQ_STAGES].coef.neg;
         dv_ff[0].rem <= '0;
         for (int i = 0; i < 4; i++) begin
            dv_ff[0].num[i] <= {sq_ff[SQ_STAGES].coef.mag[i], {FRAC_BITS{1'b0}}};
         end
      end
   end

   // Divider stages, one quotient bit per coefficient each.
   for (genvar k = 0; k < DV_STAGES - 1; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[k+1] <= div_step(dv_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[DV_STAGES] <= div_step(dv_ff[DV_STAGES-1]);
      end
   end

   // Saturation, sign and the zero-normal case.
   always_comb begin
      out_in.norm_a     = saturate(dv_ff[DV_STAGES].num[0], dv_ff[DV_STAGES].neg[0]);
      out_in.norm_b     = saturate(dv_ff[DV_STAGES].num[1], dv_ff[DV_STAGES].neg[1]);
      out_in.norm_c     = saturate(dv_ff[DV_STAGES].num[2], dv_ff[DV_STAGES].neg[2]);
      out_in.norm_d     = saturate(dv_ff[DV_STAGES].num[3], dv_ff[DV_STAGES].neg[3]);
      out_in.degenerate = dv_ff[DV_STAGES].deg;
      if (dv_ff[DV_STAGES].deg) begin
         out_in.norm_a = '0;
         out_in.norm_b = '0;
         out_in.norm_c = '0;
         out_in.norm_d = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         sqr_vld_ff <= 1'b0;
         sq_vld_ff  <= '0;
         dv_vld_ff  <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff  <= req_valid;
         sqr_vld_ff <= in_vld_ff;
         sq_vld_ff  <= {sq_vld_ff[SQ_STAGES-1:0], sqr_vld_ff};
         dv_vld_ff  <= {dv_vld_ff[DV_STAGES-1:0], sq_vld_ff[SQ_STAGES]};
         out_vld_ff <= dv_vld_ff[DV_STAGES];
      end
   end

endmodule

`default_nettype wire

FILE: design/pn_checker.sv
`default_nettype none
`include "plane_normalizer_assert.svh"

module pn_checker import pn_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // A stalled result stays put.
   `PN_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // Input is only refused while a result is waiting.
   `PN_ASSERT_NOW(a_req_ready, !rsp_valid || rsp_ready, req_ready, "input refused with free output")

   // A zero normal gives all-zero coefficients.
   `PN_ASSERT_NOW(a_degen_zero, rsp_valid && rsp_data.degenerate, (rsp_data.norm_a == '0) && (rsp_data.norm_b == '0) && (rsp_data.norm_c == '0) && (rsp_data.norm_d == '0), "degenerate item not zero")

   // A normal that is not zero gives a nonzero normalized component.
   `PN_ASSERT_NOW(a_unit_len, rsp_valid && !rsp_data.degenerate, (rsp_data.norm_a != '0) || (rsp_data.norm_b != '0) || (rsp_data.norm_c != '0), "normal lost its length")

endmodule

bind plane_normalizer pn_checker u_pn_checker (.*);

`default_nettype wire
